### rtl/core/lslf_pkg.sv
package lslf_pkg;

	// fixed field widths of the point and fit channels
	localparam int COORD_FIELD_W = 16;
	localparam int OUT_W         = 32;
	localparam int STATUS_W      = 2;

	// parameter defaults
	localparam int MAX_POINTS_DEF = 1024;
	localparam int COORD_BITS_DEF = 16;
	localparam int FRAC_BITS_DEF  = 16;

	// fit status codes
	localparam logic [STATUS_W-1:0] STS_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STS_SINGULAR  = 2'd1;
	localparam logic [STATUS_W-1:0] STS_SATURATED = 2'd2;
	localparam logic [STATUS_W-1:0] STS_OVERFLOW  = 2'd3;

	// status of an iterative arithmetic unit, seen by the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} unit_sts_t;

endpackage

### rtl/core/lslf_point_if.sv
interface lslf_point_if;
	logic                                     valid;
	logic                                     ready;
	logic signed [lslf_pkg::COORD_FIELD_W-1:0] x;
	logic signed [lslf_pkg::COORD_FIELD_W-1:0] y;
	logic                                     last;

	modport source (output valid, x, y, last, input ready);
	modport sink   (input valid, x, y, last, output ready);
endinterface

### rtl/core/lslf_fit_if.sv
interface lslf_fit_if;
	logic                                valid;
	logic                                ready;
	logic signed [lslf_pkg::OUT_W-1:0]   intercept;
	logic signed [lslf_pkg::OUT_W-1:0]   slope;
	logic        [lslf_pkg::STATUS_W-1:0] status;

	modport source (output valid, intercept, slope, status, input ready);
	modport sink   (input valid, intercept, slope, status, output ready);
endinterface

### rtl/core/lslf_mul.sv
module lslf_mul #(
	parameter int W = 43
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [W-1:0]     a,
	input  logic signed [W-1:0]     b,
	output logic signed [2*W-1:0]   p,
	output lslf_pkg::unit_sts_t     sts
);

	localparam int CW = (W > 1) ? $clog2(W) : 1;

	localparam logic [1:0] MS_IDLE = 2'd0;
	localparam logic [1:0] MS_RUN  = 2'd1;
	localparam logic [1:0] MS_FIX  = 2'd2;

	logic [1:0]     state_q;
	logic [CW-1:0]  cnt_q;
	logic [W-1:0]   mcand_q;
	logic [2*W-1:0] acc_q;
	logic           neg_q;
	logic           done_q;
	logic [2*W-1:0] p_q;

	logic [W-1:0]   a_mag;
	logic [W-1:0]   b_mag;
	logic [W:0]     hi_sum;

	assign a_mag  = a[W-1] ? (~a + 1'b1) : a;
	assign b_mag  = b[W-1] ? (~b + 1'b1) : b;
	// shift-add step: add multiplicand to the high half when the low bit is set
	assign hi_sum = {1'b0, acc_q[2*W-1:W]} + (acc_q[0] ? {1'b0, mcand_q} : {(W+1){1'b0}});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MS_IDLE;
			done_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= (state_q == MS_FIX);
			case (state_q)
				MS_IDLE: begin
					if (start) begin
						cnt_q   <= CW'(W - 1);
						state_q <= MS_RUN;
					end
				end
				MS_RUN: begin
					if (cnt_q == '0) begin
						state_q <= MS_FIX;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				MS_FIX: begin
					state_q <= MS_IDLE;
				end
				default: begin
					state_q <= MS_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			MS_IDLE: begin
				if (start) begin
					mcand_q <= a_mag;
					acc_q   <= {{W{1'b0}}, b_mag};
					neg_q   <= a[W-1] ^ b[W-1];
				end
			end
			MS_RUN: begin
				acc_q <= {hi_sum, acc_q[W-1:1]};
			end
			MS_FIX: begin
				p_q <= neg_q ? (~acc_q + 1'b1) : acc_q;
			end
			default: begin
			end
		endcase
	end

	assign p        = $signed(p_q);
	assign sts.busy = (state_q != MS_IDLE);
	assign sts.done = done_q;

endmodule

### rtl/core/lslf_div.sv
module lslf_div #(
	parameter int DW = 87,
	parameter int FB = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [DW-1:0] num,
	input  logic signed [DW-1:0] den,
	output logic [DW+FB-1:0]     q,
	output logic                 neg,
	output lslf_pkg::unit_sts_t  sts
);

	localparam int NW = DW + FB;
	localparam int CW = $clog2(NW);

	logic           run_q;
	logic           done_q;
	logic [CW-1:0]  cnt_q;
	logic [NW-1:0]  nq_q;
	logic [DW-1:0]  r_q;
	logic [DW-1:0]  d_q;
	logic           neg_q;

	logic [DW-1:0]  num_mag;
	logic [DW-1:0]  den_mag;
	logic [DW:0]    r_sh;
	logic [DW+1:0]  trial;
	logic           q_bit;

	assign num_mag = num[DW-1] ? (~num + 1'b1) : num;
	assign den_mag = den[DW-1] ? (~den + 1'b1) : den;
	// restoring step: dividend bits leave the top of nq_q, quotient bits enter below
	assign r_sh    = {r_q, nq_q[NW-1]};
	assign trial   = {1'b0, r_sh} - {2'b00, d_q};
	assign q_bit   = ~trial[DW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= run_q && (cnt_q == '0);
			if (!run_q) begin
				if (start) begin
					run_q <= 1'b1;
					cnt_q <= CW'(NW - 1);
				end
			end else if (cnt_q == '0) begin
				run_q  <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!run_q) begin
			if (start) begin
				nq_q  <= NW'(num_mag) << FB;
				d_q   <= den_mag;
				r_q   <= '0;
				neg_q <= num[DW-1] ^ den[DW-1];
			end
		end else begin
			r_q  <= q_bit ? trial[DW-1:0] : r_sh[DW-1:0];
			nq_q <= {nq_q[NW-2:0], q_bit};
		end
	end

	assign q        = nq_q;
	assign neg      = neg_q;
	assign sts.busy = run_q;
	assign sts.done = done_q;

endmodule

### rtl/core/least_squares_line_fit.sv
// First-degree least-squares line fit over a stream of integer points. Each point
// transaction is accumulated into count, sum x, sum y, sum x*x and sum x*y; points
// beyond MAX_POINTS are dropped and flagged. On the point marked last the block drops
// ready and solves the normal equations by Cramer's rule: six products on one shift-add
// multiplier of W = 2*COORD_BITS + clog2(MAX_POINTS+1) bits, then, unless the determinant
// is zero, two quotients on one restoring divider that retires one bit per cycle.
// Intercept and slope come out in signed fixed point with FRAC_BITS fraction bits,
// truncated toward zero and saturated to 32 bits, with status ok, singular, saturated
// or too many points. A finished fit waits in an output register while the next set
// of points is already being accumulated.
module least_squares_line_fit #(
	parameter int MAX_POINTS = lslf_pkg::MAX_POINTS_DEF,
	parameter int COORD_BITS = lslf_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = lslf_pkg::FRAC_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	lslf_point_if.sink      points,
	lslf_fit_if.source      fit
);

	localparam int CNT_W = $clog2(MAX_POINTS + 1);
	localparam int ACC_W = 2 * COORD_BITS + CNT_W;
	localparam int P_W   = 2 * ACC_W;
	localparam int D_W   = P_W + 1;
	localparam int Q_W   = D_W + FRAC_BITS;
	localparam int FW    = lslf_pkg::COORD_FIELD_W;
	localparam int EXT_W = (COORD_BITS > FW) ? COORD_BITS : FW;
	localparam int OW    = lslf_pkg::OUT_W;

	localparam logic [1:0] ST_ACC = 2'd0;
	localparam logic [1:0] ST_MUL = 2'd1;
	localparam logic [1:0] ST_DIV = 2'd2;
	localparam logic [1:0] ST_FIN = 2'd3;

	// product steps of the solve
	localparam logic [2:0] K_N_SXX  = 3'd0;
	localparam logic [2:0] K_SX_SX  = 3'd1;
	localparam logic [2:0] K_SXX_SY = 3'd2;
	localparam logic [2:0] K_SX_SXY = 3'd3;
	localparam logic [2:0] K_N_SXY  = 3'd4;
	localparam logic [2:0] K_SX_SY  = 3'd5;

	localparam logic [Q_W-1:0] POS_LIM = Q_W'({1'b0, {(OW-1){1'b1}}});
	localparam logic [Q_W-1:0] NEG_LIM = Q_W'({1'b1, {(OW-1){1'b0}}});

	logic [1:0]               state_q;
	logic [2:0]               k_q;
	logic                     j_q;
	logic                     mul_go_q;
	logic                     div_go_q;

	logic [CNT_W-1:0]         cnt_q;
	logic signed [ACC_W-1:0]  sx_q;
	logic signed [ACC_W-1:0]  sy_q;
	logic signed [ACC_W-1:0]  sxx_q;
	logic signed [ACC_W-1:0]  sxy_q;
	logic                     ovf_q;

	logic signed [P_W-1:0]    tmp_q;
	logic signed [D_W-1:0]    det_q;
	logic signed [D_W-1:0]    nb_q;
	logic signed [D_W-1:0]    na_q;
	logic [OW-1:0]            b_q;
	logic [OW-1:0]            a_q;
	logic                     sat_q;

	logic                     fit_valid_q;
	logic [OW-1:0]            fit_b_q;
	logic [OW-1:0]            fit_a_q;
	logic [lslf_pkg::STATUS_W-1:0] fit_sts_q;

	logic                     pt_acc;
	logic [EXT_W-1:0]         x_ext;
	logic [EXT_W-1:0]         y_ext;
	logic signed [COORD_BITS-1:0]   xc;
	logic signed [COORD_BITS-1:0]   yc;
	logic signed [2*COORD_BITS-1:0] xx;
	logic signed [2*COORD_BITS-1:0] xy;
	logic signed [ACC_W-1:0]  n_s;

	logic signed [ACC_W-1:0]  mul_a;
	logic signed [ACC_W-1:0]  mul_b;
	logic signed [P_W-1:0]    mul_p;
	lslf_pkg::unit_sts_t      mul_sts;
	logic signed [D_W-1:0]    diff;
	logic                     mul_go;
	logic                     div_go;

	logic signed [D_W-1:0]    div_num;
	logic [Q_W-1:0]           div_q;
	logic                     div_neg;
	lslf_pkg::unit_sts_t      div_sts;
	logic                     q_sat;
	logic [OW-1:0]            q_val;
	logic                     singular;
	logic                     fit_load;

	// coordinates are the low COORD_BITS bits of the fields, sign-extended
	assign x_ext   = EXT_W'($unsigned(points.x));
	assign y_ext   = EXT_W'($unsigned(points.y));
	assign xc      = $signed(x_ext[COORD_BITS-1:0]);
	assign yc      = $signed(y_ext[COORD_BITS-1:0]);
	assign xx      = xc * xc;
	assign xy      = xc * yc;
	assign n_s     = $signed(ACC_W'(cnt_q));

	assign points.ready = (state_q == ST_ACC);
	assign pt_acc       = points.valid && points.ready;

	always_comb begin
		case (k_q)
			K_N_SXX:  begin mul_a = n_s;  mul_b = sxx_q; end
			K_SX_SX:  begin mul_a = sx_q; mul_b = sx_q;  end
			K_SXX_SY: begin mul_a = sxx_q; mul_b = sy_q; end
			K_SX_SXY: begin mul_a = sx_q; mul_b = sxy_q; end
			K_N_SXY:  begin mul_a = n_s;  mul_b = sxy_q; end
			K_SX_SY:  begin mul_a = sx_q; mul_b = sy_q;  end
			default:  begin mul_a = '0;   mul_b = '0;    end
		endcase
	end

	assign diff = D_W'(tmp_q) - D_W'(mul_p);

	// unit start pulses for the next cycle
	assign mul_go = ((state_q == ST_ACC) && pt_acc && points.last)
	             || ((state_q == ST_MUL) && mul_sts.done && (k_q != K_SX_SY));
	assign div_go = ((state_q == ST_MUL) && mul_sts.done && (k_q == K_SX_SY) && !singular)
	             || ((state_q == ST_DIV) && div_sts.done && !j_q);

	lslf_mul #(
		.W (ACC_W)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_go_q),
		.a      (mul_a),
		.b      (mul_b),
		.p      (mul_p),
		.sts    (mul_sts)
	);

	assign div_num = j_q ? na_q : nb_q;

	lslf_div #(
		.DW (D_W),
		.FB (FRAC_BITS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_go_q),
		.num    (div_num),
		.den    (det_q),
		.q      (div_q),
		.neg    (div_neg),
		.sts    (div_sts)
	);

	assign q_sat    = div_neg ? (div_q > NEG_LIM) : (div_q > POS_LIM);
	assign q_val    = div_neg ? (div_neg && q_sat ? NEG_LIM[OW-1:0] : (~div_q[OW-1:0] + 1'b1))
	                          : (q_sat ? POS_LIM[OW-1:0] : div_q[OW-1:0]);
	assign singular = (det_q == '0);
	assign fit_load = (state_q == ST_FIN) && (!fit_valid_q || fit.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_ACC;
			k_q         <= K_N_SXX;
			j_q         <= 1'b0;
			mul_go_q    <= 1'b0;
			div_go_q    <= 1'b0;
			cnt_q       <= '0;
			sx_q        <= '0;
			sy_q        <= '0;
			sxx_q       <= '0;
			sxy_q       <= '0;
			ovf_q       <= 1'b0;
			fit_valid_q <= 1'b0;
		end else begin
			mul_go_q <= mul_go;
			div_go_q <= div_go;
			if (fit_load) begin
				fit_valid_q <= 1'b1;
			end else if (fit.valid && fit.ready) begin
				fit_valid_q <= 1'b0;
			end
			case (state_q)
				ST_ACC: begin
					if (pt_acc) begin
						if (cnt_q < CNT_W'(MAX_POINTS)) begin
							cnt_q <= cnt_q + 1'b1;
							sx_q  <= sx_q + ACC_W'(xc);
							sy_q  <= sy_q + ACC_W'(yc);
							sxx_q <= sxx_q + ACC_W'(xx);
							sxy_q <= sxy_q + ACC_W'(xy);
						end else begin
							ovf_q <= 1'b1;
						end
						if (points.last) begin
							state_q  <= ST_MUL;
							k_q      <= K_N_SXX;
						end
					end
				end
				ST_MUL: begin
					if (mul_sts.done) begin
						if (k_q == K_SX_SY) begin
							if (singular) begin
								state_q <= ST_FIN;
							end else begin
								state_q  <= ST_DIV;
								j_q      <= 1'b0;
							end
						end else begin
							k_q      <= k_q + 1'b1;
						end
					end
				end
				ST_DIV: begin
					if (div_sts.done) begin
						if (j_q) begin
							state_q <= ST_FIN;
						end else begin
							j_q      <= 1'b1;
						end
					end
				end
				ST_FIN: begin
					if (fit_load) begin
						state_q     <= ST_ACC;
						cnt_q       <= '0;
						sx_q        <= '0;
						sy_q        <= '0;
						sxx_q       <= '0;
						sxy_q       <= '0;
						ovf_q       <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_ACC;
				end
			endcase
		end
	end

	// solve datapath, no reset needed
	always_ff @(posedge clk) begin
		if (state_q == ST_MUL && mul_sts.done) begin
			case (k_q)
				K_SX_SX:  det_q <= diff;
				K_SX_SXY: nb_q  <= diff;
				K_SX_SY:  na_q  <= diff;
				default:  tmp_q <= mul_p;
			endcase
		end
		if (state_q == ST_MUL) begin
			sat_q <= 1'b0;
		end
		if (state_q == ST_DIV && div_sts.done) begin
			if (j_q) begin
				a_q <= q_val;
			end else begin
				b_q <= q_val;
			end
			sat_q <= sat_q | q_sat;
		end
		if (fit_load) begin
			if (singular) begin
				fit_b_q   <= '0;
				fit_a_q   <= '0;
				fit_sts_q <= lslf_pkg::STS_SINGULAR;
			end else begin
				fit_b_q   <= b_q;
				fit_a_q   <= a_q;
				fit_sts_q <= ovf_q ? lslf_pkg::STS_OVERFLOW
				           : (sat_q ? lslf_pkg::STS_SATURATED : lslf_pkg::STS_OK);
			end
		end
	end

	assign fit.valid     = fit_valid_q;
	assign fit.intercept = $signed(fit_b_q);
	assign fit.slope     = $signed(fit_a_q);
	assign fit.status    = fit_sts_q;

	a_last_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(pt_acc && points.last) |=> !points.ready)
		else $error("point accepted right after a last point");

	a_cnt_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_POINTS))
		else $error("point count beyond capacity");

	a_mul_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mul_go_q |-> !mul_sts.busy)
		else $error("multiplier started while busy");

	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_go_q |-> (!div_sts.busy && !mul_sts.busy))
		else $error("divider started while a unit is busy");

	a_fit_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(fit.valid) |-> $past(state_q == ST_FIN))
		else $error("fit presented outside the finish step");

	a_singular_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(fit.valid && fit.status == lslf_pkg::STS_SINGULAR) |->
		(fit.intercept == '0 && fit.slope == '0))
		else $error("singular fit with nonzero fields");

endmodule

### test/tb_top.sv
typedef struct {
	logic signed [lslf_pkg::OUT_W-1:0]    intercept;
	logic signed [lslf_pkg::OUT_W-1:0]    slope;
	logic        [lslf_pkg::STATUS_W-1:0] status;
} line_fit_t;

class fit_scoreboard;
	localparam int CAPACITY  = lslf_pkg::MAX_POINTS_DEF;
	localparam int CRD_BITS  = lslf_pkg::COORD_BITS_DEF;
	localparam int FRAC      = lslf_pkg::FRAC_BITS_DEF;

	int unsigned held;
	longint      sx;
	longint      sy;
	longint      sxx;
	longint      sxy;
	bit          dropped;

	line_fit_t   pending_fits[$];
	int          errors;
	int          points_seen;
	int          fits_checked;
	int          status_hits[4];

	function new();
		clear_sums();
		errors = 0;
		points_seen = 0;
		fits_checked = 0;
		foreach (status_hits[i]) status_hits[i] = 0;
	endfunction

	function void clear_sums();
		held = 0;
		sx = 0;
		sy = 0;
		sxx = 0;
		sxy = 0;
		dropped = 0;
	endfunction

	function int pending();
		return pending_fits.size();
	endfunction

	// truncating fixed point quotient with 32 bit saturation
	function logic [lslf_pkg::OUT_W-1:0] to_fixed(logic signed [127:0] num,
			logic signed [127:0] den, inout bit sat);
		logic [127:0] nm;
		logic [127:0] dm;
		logic [127:0] q;
		bit           neg;
		neg = num[127] ^ den[127];
		nm = num[127] ? 128'(-num) : 128'(num);
		dm = den[127] ? 128'(-den) : 128'(den);
		nm = nm << FRAC;
		q = nm / dm;
		if (neg) begin
			if (q > 128'h8000_0000) begin
				sat = 1'b1;
				return 32'h8000_0000;
			end
			return -q[31:0];
		end
		if (q > 128'h7fff_ffff) begin
			sat = 1'b1;
			return 32'h7fff_ffff;
		end
		return q[31:0];
	endfunction

	function void note_point(logic signed [lslf_pkg::COORD_FIELD_W-1:0] x,
			logic signed [lslf_pkg::COORD_FIELD_W-1:0] y, logic last);
		longint             xv;
		longint             yv;
		logic signed [127:0] n_w;
		logic signed [127:0] sx_w;
		logic signed [127:0] sy_w;
		logic signed [127:0] sxx_w;
		logic signed [127:0] sxy_w;
		logic signed [127:0] det;
		line_fit_t          fit;
		bit                 sat;
		xv = x;
		yv = y;
		xv = (xv <<< (64 - CRD_BITS)) >>> (64 - CRD_BITS);
		yv = (yv <<< (64 - CRD_BITS)) >>> (64 - CRD_BITS);
		points_seen++;
		if (held < CAPACITY) begin
			held++;
			sx += xv;
			sy += yv;
			sxx += xv * xv;
			sxy += xv * yv;
		end else begin
			dropped = 1'b1;
		end
		if (!last) return;

		n_w = held;
		sx_w = sx;
		sy_w = sy;
		sxx_w = sxx;
		sxy_w = sxy;
		det = n_w * sxx_w - sx_w * sx_w;
		sat = 1'b0;
		if (det == 0) begin
			fit.intercept = '0;
			fit.slope = '0;
			fit.status = lslf_pkg::STS_SINGULAR;
		end else begin
			fit.intercept = to_fixed(sxx_w * sy_w - sx_w * sxy_w, det, sat);
			fit.slope = to_fixed(n_w * sxy_w - sx_w * sy_w, det, sat);
			if (dropped)
				fit.status = lslf_pkg::STS_OVERFLOW;
			else if (sat)
				fit.status = lslf_pkg::STS_SATURATED;
			else
				fit.status = lslf_pkg::STS_OK;
		end
		pending_fits = {pending_fits, fit};
		clear_sums();
	endfunction

	function void check_fit(line_fit_t got);
		line_fit_t want;
		if (pending_fits.size() == 0) begin
			$display("%0t: fit transaction with nothing expected: intercept %h slope %h status %0d",
				$time, got.intercept, got.slope, got.status);
			errors++;
			return;
		end
		want = pending_fits.pop_front();
		fits_checked++;
		status_hits[want.status]++;
		if (got.intercept !== want.intercept) begin
			$display("%0t: intercept mismatch: expected %h actual %h", $time,
				want.intercept, got.intercept);
			errors++;
		end
		if (got.slope !== want.slope) begin
			$display("%0t: slope mismatch: expected %h actual %h", $time,
				want.slope, got.slope);
			errors++;
		end
		if (got.status !== want.status) begin
			$display("%0t: status mismatch: expected %0d actual %0d", $time,
				want.status, got.status);
			errors++;
		end
	endfunction
endclass

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum int {
		SET_WIDE,
		SET_NARROW_X,
		SET_SAME_X,
		SET_SINGLE,
		SET_TINY,
		SET_LINE
	} set_kind_t;

	localparam int ITEM_TARGET = 1850;
	localparam int DRAIN_WAIT  = 700;

	logic clk = 1'b0;
	logic arst_n;

	lslf_point_if point_bus();
	lslf_fit_if   fit_bus();

	least_squares_line_fit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.points (point_bus),
		.fit    (fit_bus)
	);

	fit_scoreboard sb = new();

	int items_sent = 0;
	int burst_left = 0;
	int stall_left = 0;
	int rx_cycle   = 0;
	bit calm       = 1'b0;

	always #5 clk = ~clk;

	always @(posedge clk)
		if (arst_n && point_bus.valid && point_bus.ready)
			sb.note_point(point_bus.x, point_bus.y, point_bus.last);

	always @(posedge clk) begin
		line_fit_t got;
		if (arst_n && fit_bus.valid && fit_bus.ready) begin
			got.intercept = fit_bus.intercept;
			got.slope = fit_bus.slope;
			got.status = fit_bus.status;
			sb.check_fit(got);
		end
	end

	// receiver: alternating calm stretches and stall-heavy stretches
	always @(posedge clk) begin
		rx_cycle++;
		if (rx_cycle % 3000 == 0)
			calm = ~calm;
		if (stall_left > 0) begin
			stall_left--;
			fit_bus.ready <= 1'b0;
		end else if (calm) begin
			fit_bus.ready <= 1'b1;
		end else begin
			case ($urandom_range(0, 9))
				0: begin
					stall_left = $urandom_range(1, 40);
					fit_bus.ready <= 1'b0;
				end
				1, 2: fit_bus.ready <= 1'b0;
				default: fit_bus.ready <= 1'b1;
			endcase
		end
	end

	task automatic send_point(input logic signed [lslf_pkg::COORD_FIELD_W-1:0] x,
			input logic signed [lslf_pkg::COORD_FIELD_W-1:0] y, input bit last);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				point_bus.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		point_bus.valid <= 1'b1;
		point_bus.x <= x;
		point_bus.y <= y;
		point_bus.last <= last;
		do @(posedge clk); while (!point_bus.ready);
		items_sent++;
	endtask

	// hold the sender off until every pending fit has come out
	task automatic drain_fits();
		point_bus.valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic random_set();
		set_kind_t kind;
		int        len;
		int        i;
		int        k;
		int        b;
		logic signed [lslf_pkg::COORD_FIELD_W-1:0] xb;
		logic signed [lslf_pkg::COORD_FIELD_W-1:0] xv;
		logic signed [lslf_pkg::COORD_FIELD_W-1:0] yv;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: kind = SET_WIDE;
			4: kind = SET_NARROW_X;
			5: kind = SET_SAME_X;
			6: kind = SET_SINGLE;
			7: kind = SET_TINY;
			default: kind = SET_LINE;
		endcase
		len = (kind == SET_SINGLE) ? 1 : $urandom_range(2, 12);
		xb = 16'($urandom());
		k = $urandom_range(0, 16) - 8;
		b = $urandom_range(0, 2000) - 1000;
		for (i = 0; i < len; i++) begin
			case (kind)
				SET_NARROW_X: begin
					xv = xb + 16'($urandom_range(0, 1));
					yv = 16'($urandom());
				end
				SET_SAME_X: begin
					xv = xb;
					yv = 16'($urandom());
				end
				SET_TINY: begin
					xv = 16'($urandom_range(0, 8) - 4);
					yv = 16'($urandom_range(0, 8) - 4);
				end
				SET_LINE: begin
					xv = 16'($urandom_range(0, 400) - 200);
					yv = 16'(k * xv + b + $urandom_range(0, 2) - 1);
				end
				default: begin
					xv = 16'($urandom());
					yv = 16'($urandom());
				end
			endcase
			send_point(xv, yv, i == len - 1);
		end
	endtask

	task automatic capacity_set();
		int len;
		int i;
		len = lslf_pkg::MAX_POINTS_DEF + $urandom_range(1, 4);
		for (i = 0; i < len; i++)
			send_point(16'($urandom()), 16'($urandom()), i == len - 1);
	endtask

	initial begin
		bit long_done;
		long_done = 1'b0;
		arst_n <= 1'b0;
		point_bus.valid <= 1'b0;
		point_bus.x <= '0;
		point_bus.y <= '0;
		point_bus.last <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// one point only: singular
		send_point(-16'sd32768, 16'sd32767, 1'b1);
		// steep rise between adjacent x: slope saturates high
		send_point(16'sd0, -16'sd32768, 1'b0);
		send_point(16'sd1, 16'sd32767, 1'b1);
		// all x equal: singular
		send_point(16'sd5, 16'sd1, 1'b0);
		send_point(16'sd5, 16'sd2, 1'b0);
		send_point(16'sd5, 16'sd3, 1'b1);
		// corners of the coordinate range
		send_point(-16'sd32768, -16'sd32768, 1'b0);
		send_point(16'sd32767, 16'sd32767, 1'b0);
		send_point(-16'sd32768, 16'sd32767, 1'b0);
		send_point(16'sd32767, -16'sd32768, 1'b1);
		// exact line y = 2x + 3
		send_point(16'sd0, 16'sd3, 1'b0);
		send_point(16'sd1, 16'sd5, 1'b0);
		send_point(-16'sd1, 16'sd1, 1'b0);
		send_point(16'sd2, 16'sd7, 1'b1);
		// steep fall far from origin: both fields saturate
		send_point(16'sd32766, 16'sd32767, 1'b0);
		send_point(16'sd32767, -16'sd32768, 1'b1);
		// all-ones and zero coordinates
		send_point(-16'sd1, -16'sd1, 1'b0);
		send_point(16'sd0, 16'sd0, 1'b1);

		drain_fits();

		while (items_sent < ITEM_TARGET) begin
			if (!long_done && items_sent > 400) begin
				capacity_set();
				long_done = 1'b1;
			end else begin
				random_set();
			end
			if ($urandom_range(0, 59) == 0)
				drain_fits();
		end
		point_bus.valid <= 1'b0;

		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("covered %0d point transactions and %0d fits", sb.points_seen,
			sb.fits_checked);
		$display("fit status mix: ok %0d, singular %0d, saturated %0d, too many points %0d",
			sb.status_hits[lslf_pkg::STS_OK], sb.status_hits[lslf_pkg::STS_SINGULAR],
			sb.status_hits[lslf_pkg::STS_SATURATED], sb.status_hits[lslf_pkg::STS_OVERFLOW]);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("timeout with %0d fits still pending", sb.pending());
		$display("[FAIL] regression broken");
		$finish;
	end
endmodule

### sim.f
rtl/core/lslf_pkg.sv
rtl/core/lslf_point_if.sv
rtl/core/lslf_fit_if.sv
rtl/core/lslf_mul.sv
rtl/core/lslf_div.sv
rtl/core/least_squares_line_fit.sv
test/tb_top.sv
